// ===== sv/afc_pkg.sv =====
// Package: shared types and constants for the box/frustum classifier.
package afc_pkg;

    localparam int COORD_BITS     = 16;
    localparam int COEF_BITS      = 16;
    localparam int OFS_BITS       = 16;
    localparam int NUM_PLANES     = 6;
    localparam int NUM_AXES       = 3;
    localparam int COEF_FRAC_BITS = 14;
    localparam int PROD_W         = COEF_BITS + COORD_BITS;
    localparam int DIST_W         = PROD_W + 3;
    localparam int CFG_IDX_W      = 3;

    localparam logic [1:0] VIS_INSIDE    = 2'd0;
    localparam logic [1:0] VIS_INTERSECT = 2'd1;
    localparam logic [1:0] VIS_OUTSIDE   = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COEF_BITS-1:0]  coef_t;
    typedef logic signed [PROD_W-1:0]     prod_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    typedef struct packed {
        logic [1:0] visibility;
        logic       fully_outside;
    } result_t;

    // a in the low bits, d in the high bits
    typedef struct packed {
        logic signed [OFS_BITS-1:0] d;
        coef_t                      c;
        coef_t                      b;
        coef_t                      a;
    } plane_t;

    typedef plane_t [NUM_PLANES-1:0] plane_set_t;

    // Corner coordinates, one per axis (0 = x, 1 = y, 2 = z)
    typedef coord_t [NUM_AXES-1:0] corner_t;
    typedef corner_t [NUM_PLANES-1:0] corner_set_t;

    typedef prod_t [NUM_AXES-1:0] prod_row_t;
    typedef prod_row_t [NUM_PLANES-1:0] prod_set_t;

    // Pipeline control between stages
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    function automatic coef_t plane_coef(input plane_t p, input int ax);
        coef_t r;
        case (ax)
            0:       r = p.a;
            1:       r = p.b;
            default: r = p.c;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/afc_corner_sel.sv =====
// Stage 1: near and far corner selection for each plane.
module afc_corner_sel (
    input  logic                clk,
    input  logic                rst_n,
    input  afc_pkg::pipe_ctl_t  ctl_in,
    input  afc_pkg::box_t       box,
    input  afc_pkg::plane_set_t planes,
    output afc_pkg::pipe_ctl_t  ctl_out,
    output afc_pkg::corner_set_t near_c,
    output afc_pkg::corner_set_t far_c
);
    import afc_pkg::*;

    logic        valid_reg;
    corner_set_t near_reg;
    corner_set_t near_next;
    corner_set_t far_reg;
    corner_set_t far_next;
    corner_t     lo;
    corner_t     hi;

    assign lo = {box.min_z, box.min_y, box.min_x};
    assign hi = {box.max_z, box.max_y, box.max_x};

    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int ax = 0; ax < NUM_AXES; ax++)
            begin
                // zero coefficient counts as non-negative
                if (plane_coef(planes[p], ax) < 0)
                begin
                    near_next[p][ax] = hi[ax];
                    far_next[p][ax]  = lo[ax];
                end
                else
                begin
                    near_next[p][ax] = lo[ax];
                    far_next[p][ax]  = hi[ax];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl_in.en)
            valid_reg <= ctl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.en)
        begin
            near_reg <= near_next;
            far_reg  <= far_next;
        end
    end

    assign ctl_out.en    = ctl_in.en;
    assign ctl_out.valid = valid_reg;
    assign near_c        = near_reg;
    assign far_c         = far_reg;

endmodule

// ===== sv/afc_dist.sv =====
// Stages 2 and 3: per-axis products, then plane distance sign flags.
module afc_dist (
    input  logic                 clk,
    input  logic                 rst_n,
    input  afc_pkg::pipe_ctl_t   ctl_in,
    input  afc_pkg::corner_set_t near_c,
    input  afc_pkg::corner_set_t far_c,
    input  afc_pkg::plane_set_t  planes,
    output afc_pkg::pipe_ctl_t   ctl_out,
    output logic [afc_pkg::NUM_PLANES-1:0] near_pos,
    output logic [afc_pkg::NUM_PLANES-1:0] far_pos
);
    import afc_pkg::*;

    logic      valid_b_reg;
    logic      valid_c_reg;
    prod_set_t near_prod_reg;
    prod_set_t near_prod_next;
    prod_set_t far_prod_reg;
    prod_set_t far_prod_next;
    logic [NUM_PLANES-1:0] near_pos_reg;
    logic [NUM_PLANES-1:0] near_pos_next;
    logic [NUM_PLANES-1:0] far_pos_reg;
    logic [NUM_PLANES-1:0] far_pos_next;

    always_comb
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            for (int ax = 0; ax < NUM_AXES; ax++)
            begin
                near_prod_next[p][ax] = $signed(plane_coef(planes[p], ax))
                                      * $signed(near_c[p][ax]);
                far_prod_next[p][ax]  = $signed(plane_coef(planes[p], ax))
                                      * $signed(far_c[p][ax]);
            end
        end
    end

    always_comb
    begin
        logic signed [DIST_W-1:0] ofs;
        logic signed [DIST_W-1:0] dn;
        logic signed [DIST_W-1:0] df;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            // d is an integer, products are Q.14
            ofs = DIST_W'($signed(planes[p].d)) <<< COEF_FRAC_BITS;
            dn  = DIST_W'($signed(near_prod_reg[p][0]))
                + DIST_W'($signed(near_prod_reg[p][1]))
                + DIST_W'($signed(near_prod_reg[p][2])) - ofs;
            df  = DIST_W'($signed(far_prod_reg[p][0]))
                + DIST_W'($signed(far_prod_reg[p][1]))
                + DIST_W'($signed(far_prod_reg[p][2])) - ofs;
            near_pos_next[p] = (dn > 0);
            far_pos_next[p]  = (df > 0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (ctl_in.en)
        begin
            valid_b_reg <= ctl_in.valid;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.en)
        begin
            near_prod_reg <= near_prod_next;
            far_prod_reg  <= far_prod_next;
            near_pos_reg  <= near_pos_next;
            far_pos_reg   <= far_pos_next;
        end
    end

    assign ctl_out.en    = ctl_in.en;
    assign ctl_out.valid = valid_c_reg;
    assign near_pos      = near_pos_reg;
    assign far_pos       = far_pos_reg;

endmodule

// ===== sv/afc_reduce.sv =====
// Stage 4: combine plane flags into the visibility result (output register).
module afc_reduce (
    input  logic               clk,
    input  logic               rst_n,
    input  afc_pkg::pipe_ctl_t ctl_in,
    input  logic [afc_pkg::NUM_PLANES-1:0] near_pos,
    input  logic [afc_pkg::NUM_PLANES-1:0] far_pos,
    output logic               res_valid,
    output afc_pkg::result_t   res
);
    import afc_pkg::*;

    logic    valid_reg;
    result_t res_reg;
    result_t res_next;

    always_comb
    begin
        res_next.fully_outside = |near_pos;
        if (|near_pos)
            res_next.visibility = VIS_OUTSIDE;
        else if (|far_pos)
            res_next.visibility = VIS_INTERSECT;
        else
            res_next.visibility = VIS_INSIDE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctl_in.en)
            valid_reg <= ctl_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (ctl_in.en)
            res_reg <= res_next;
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

// ===== sv/aabb_frustum_classify_top.sv =====
// Top level: box against six-plane frustum classifier, plane registers and pipeline.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------
//  in      | request   | in_valid/in_stall  | in_data  (box_t)
//  out     | result    | out_valid/out_stall| out_data (result_t)
//  cfg     | write     | cfg_valid/cfg_ready| cfg_index, cfg_data (plane)
//
// One box per cycle while a stalled result does not freeze the pipeline; stages are select, multiply, sum, reduce.
// One 16x16 signed multiply sets the depth of the multiply stage; all 36 run side by side.
// Reset clears all valid bits and the six planes (every box reads inside).
// A stalled result freezes the whole pipeline; in_stall rises only then.
module aabb_frustum_classify_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  afc_pkg::box_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output afc_pkg::result_t                  out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [afc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [63:0]                       cfg_data
);
    import afc_pkg::*;

    plane_set_t  plane_reg;
    pipe_ctl_t   ctl_in;
    pipe_ctl_t   ctl_sel;
    pipe_ctl_t   ctl_dist;
    corner_set_t near_c;
    corner_set_t far_c;
    logic [NUM_PLANES-1:0] near_pos;
    logic [NUM_PLANES-1:0] far_pos;
    logic        pipe_en;

    assign cfg_ready = 1'b1;

    // indexes past the last plane are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plane_reg <= '0;
        else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_PLANES)))
            plane_reg[cfg_index] <= plane_t'(cfg_data);
    end

    assign pipe_en      = !out_valid || !out_stall;
    assign in_stall     = !pipe_en;
    assign ctl_in.en    = pipe_en;
    assign ctl_in.valid = in_valid;

    afc_corner_sel u_sel (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl_in  (ctl_in),
        .box     (in_data),
        .planes  (plane_reg),
        .ctl_out (ctl_sel),
        .near_c  (near_c),
        .far_c   (far_c)
    );

    afc_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (ctl_sel),
        .near_c   (near_c),
        .far_c    (far_c),
        .planes   (plane_reg),
        .ctl_out  (ctl_dist),
        .near_pos (near_pos),
        .far_pos  (far_pos)
    );

    afc_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl_in    (ctl_dist),
        .near_pos  (near_pos),
        .far_pos   (far_pos),
        .res_valid (out_valid),
        .res       (out_data)
    );

endmodule
